/* hdl/bfa_pkg.sv */
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int MAX_FRAMES_DEF  = 4096;
  localparam int FRAME_BYTES_DEF = 4096;

  localparam int WORD_BITS = 32;
  localparam int WORD_LOG2 = 5;

  localparam int ADDR_W   = 24;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 13;
  localparam int FC_W     = 13;
  localparam int APB_W    = 32;

  localparam logic [FC_W-1:0] FC_RESET  = 13'd4096;
  localparam int              TOTAL_MAX = 8191;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REINIT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic                 found;
    logic [WORD_LOG2-1:0] bit_idx;
  } find_res_t;

endpackage

/* hdl/bitmap_frame_allocator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   in_cmd, in_phys_address
// out_      output     out_valid / out_stall out_result_address, out_status, out_used_total
// APB       config     psel/penable/pready   paddr, pwdata, prdata (frame_count at 0x0)
//
// One item at a time; the output register loads as the block returns to idle, ready for
// the next item. Free and reserve: read, modify, write back. Allocate: one 32-bit map word
// read per cycle, at most ceil(min(frame_count, MAX_FRAMES)/32) words scanned. Reinit: all
// MAP_WORDS words written, one word a cycle. After reset the map is filled with ones over
// MAP_WORDS words (128 by default), no item taken meanwhile. A stalled result waits in the
// output register while the next item is already accepted. FRAME_BYTES must be a power of two.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [ADDR_W-1:0]   in_phys_address,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_result_address,
  output logic [STATUS_W-1:0] out_status,
  output logic [TOTAL_W-1:0]  out_used_total,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]    prdata,
  output logic                pready
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WC_W      = $clog2(MAP_WORDS + 1);
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int FB_LOG2   = $clog2(FRAME_BYTES);
  localparam int FI_W      = ADDR_W - FB_LOG2;
  localparam int FF_W      = WI_W + WORD_LOG2;

  localparam logic [WI_W-1:0] LAST_WORD = WI_W'(MAP_WORDS - 1);

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RMW  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [FC_W-1:0]      fc_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WI_W-1:0]      fill_w_r, fill_w_nxt;
  logic                 fill_resp_r, fill_resp_nxt;
  logic [WC_W-1:0]      scan_w_r, scan_w_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [WI_W-1:0]      chk_w_r, chk_w_nxt;
  logic [WI_W-1:0]      rmw_w_r, rmw_w_nxt;
  logic [WORD_LOG2-1:0] rmw_b_r, rmw_b_nxt;
  logic                 rmw_take_r, rmw_take_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;

  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [TOTAL_W-1:0]   out_total_r;

  logic                 ram_we, ram_re;
  logic [WI_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rd_data;

  logic [CNT_W-1:0]     lim;
  logic [FI_W-1:0]      in_frame;
  logic                 in_range;
  logic [WI_W-1:0]      last_w;
  logic [31:0]          rem;
  logic [WORD_BITS-1:0] elig, free_vec, rmw_mask;
  find_res_t            fr;
  logic [FF_W-1:0]      found_f;
  logic [FF_W+FB_LOG2-1:0] found_addr;
  logic                 accept, out_free, rmw_old;

  bfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WI_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  bfa_free_find u_find (
    .vec (free_vec),
    .res (fr)
  );

  // effective frame count, clamped to the map size
  assign lim      = (32'(fc_r) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : CNT_W'(fc_r);
  assign in_frame = in_phys_address[ADDR_W-1:FB_LOG2];
  assign in_range = 32'(in_frame) < 32'(lim);
  assign last_w   = WI_W'((lim - CNT_W'(1)) >> WORD_LOG2);

  // frames of the word under check that lie below the limit; frame 0 never goes out
  assign rem = 32'(lim) - 32'({chk_w_r, {WORD_LOG2{1'b0}}});
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      elig[b] = (32'(b) < rem) && !((chk_w_r == '0) && (b == 0));
    end
  end
  assign free_vec   = ~rd_data & elig;
  assign found_f    = {chk_w_r, fr.bit_idx};
  assign found_addr = (FF_W + FB_LOG2)'(found_f) << FB_LOG2;

  assign rmw_mask = WORD_BITS'(1) << rmw_b_r;
  assign rmw_old  = rd_data[rmw_b_r];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_w_nxt     = fill_w_r;
    fill_resp_nxt  = fill_resp_r;
    scan_w_nxt     = scan_w_r;
    chk_vld_nxt    = chk_vld_r;
    chk_w_nxt      = chk_w_r;
    rmw_w_nxt      = rmw_w_r;
    rmw_b_nxt      = rmw_b_r;
    rmw_take_nxt   = rmw_take_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_w_r;
        ram_wdata = '1;
        if (fill_w_r == LAST_WORD) begin
          state_nxt     = fill_resp_r ? S_DONE : S_IDLE;
          fill_resp_nxt = 1'b0;
        end else begin
          fill_w_nxt = fill_w_r + WI_W'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          unique case (in_cmd)
            CMD_ALLOC: begin
              if (32'(lim) < 32'd2) begin
                res_status_nxt = ST_OOM;
                state_nxt      = S_DONE;
              end else begin
                scan_w_nxt  = '0;
                chk_vld_nxt = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            CMD_FREE, CMD_RESERVE: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = WI_W'(in_frame >> WORD_LOG2);
                rmw_w_nxt    = WI_W'(in_frame >> WORD_LOG2);
                rmw_b_nxt    = in_frame[WORD_LOG2-1:0];
                rmw_take_nxt = (in_cmd == CMD_RESERVE);
                state_nxt    = S_RMW;
              end
            end
            CMD_REINIT: begin
              cnt_nxt       = lim;
              fill_w_nxt    = '0;
              fill_resp_nxt = 1'b1;
              state_nxt     = S_FILL;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one word per cycle, check the word read in the cycle before
        chk_vld_nxt = 1'b0;
        if (scan_w_r <= WC_W'(last_w)) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_w_r[WI_W-1:0];
          chk_vld_nxt = 1'b1;
          chk_w_nxt   = scan_w_r[WI_W-1:0];
          scan_w_nxt  = scan_w_r + WC_W'(1);
        end
        if (chk_vld_r) begin
          if (fr.found) begin
            ram_we       = 1'b1;
            ram_waddr    = chk_w_r;
            ram_wdata    = rd_data | (WORD_BITS'(1) << fr.bit_idx);
            cnt_nxt      = cnt_r + CNT_W'(1);
            res_addr_nxt = found_addr[ADDR_W-1:0];
            state_nxt    = S_DONE;
          end else if (chk_w_r == last_w) begin
            res_status_nxt = ST_OOM;
            state_nxt      = S_DONE;
          end
        end
      end

      S_RMW: begin
        ram_waddr = rmw_w_r;
        if (rmw_take_r) begin
          ram_wdata = rd_data | rmw_mask;
          if (!rmw_old) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          ram_wdata = rd_data & ~rmw_mask;
          if (rmw_old) begin
            ram_we = 1'b1;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_w_r    <= '0;
      fill_resp_r <= 1'b0;
      cnt_r       <= CNT_W'(MAX_FRAMES);
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fc_r        <= FC_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_w_r    <= fill_w_nxt;
      fill_resp_r <= fill_resp_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && pready) begin
        fc_r <= pwdata[FC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_w_r     <= scan_w_nxt;
    chk_w_r      <= chk_w_nxt;
    rmw_w_r      <= rmw_w_nxt;
    rmw_b_r      <= rmw_b_nxt;
    rmw_take_r   <= rmw_take_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_total_r  <= (32'(cnt_r) > 32'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(cnt_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_used_total     = out_total_r;

  assign prdata = APB_W'(fc_r);
  assign pready = 1'b1;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_FRAMES))
    else $error("used count above map size");

  a_rmw_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_FREE || in_cmd == CMD_RESERVE) && in_range)
      |=> (state_r == S_RMW))
    else $error("in-range free/reserve did not go to read-modify-write");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && chk_vld_r) |-> (chk_w_r <= last_w))
    else $error("scan checked a word beyond the frame limit");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("map written while idle");
`endif

endmodule

/* hdl/bfa_map_ram.sv */
`timescale 1ns / 1ps

module bfa_map_ram
  import bfa_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bfa_free_find.sv */
`timescale 1ns / 1ps

// Lowest set bit of a map word (set = free and eligible).
module bfa_free_find
  import bfa_pkg::*;
(
  input  logic [WORD_BITS-1:0] vec,
  output find_res_t            res
);

  always_comb begin
    res.found   = |vec;
    res.bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (vec[b]) begin
        res.bit_idx = WORD_LOG2'(b);
      end
    end
  end

endmodule

/* sim/bitmap_frame_allocator_test.sv */
`timescale 1ns / 1ps

module bitmap_frame_allocator_test;
  import bfa_pkg::*;

  localparam int MAP_WORDS   = MAX_FRAMES_DEF / WORD_BITS;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 1500;

  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total;
  } outcome_t;

  typedef struct packed {
    bit                 is_cfg;
    bit                 typed;
    logic [FC_W-1:0]    fc;
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  addr;
    outcome_t           exp;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [ADDR_W-1:0]   in_phys_address;
  logic                out_valid;
  logic                out_stall;
  logic [ADDR_W-1:0]   out_result_address;
  logic [STATUS_W-1:0] out_status;
  logic [TOTAL_W-1:0]  out_used_total;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [1:0]          paddr;
  logic [APB_W-1:0]    pwdata;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  // shadow of the allocator state
  bit [WORD_BITS-1:0] frame_map [MAP_WORDS];
  int                 frames_used;
  int                 frame_count_reg;

  outcome_t expected_outcomes [$];
  row_t     plan [$];
  int       err_count = 0;
  int       items_sent = 0;
  bit       hold_req = 1'b0;
  bit       no_gaps = 1'b0;

  bitmap_frame_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_phys_address    (in_phys_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_used_total     (out_used_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int frame_limit();
    return (frame_count_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_count_reg;
  endfunction

  function automatic bit frame_used(input int f);
    return frame_map[f / WORD_BITS][f % WORD_BITS];
  endfunction

  function automatic void mark_all_used();
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '1;
  endfunction

  function automatic void predict_outcome(input logic [CMD_W-1:0] c,
                                          input logic [ADDR_W-1:0] a,
                                          output outcome_t o);
    int lim;
    int f;
    bit found;
    lim = frame_limit();
    o = '0;
    o.status = ST_OK;
    found = 1'b0;
    case (c)
      CMD_ALLOC: begin
        for (f = 1; f < lim && !found; f++) begin
          if (!frame_used(f)) begin
            frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
            frames_used++;
            o.addr = ADDR_W'(f * FRAME_BYTES_DEF);
            found = 1'b1;
          end
        end
        if (!found) o.status = ST_OOM;
      end
      CMD_FREE, CMD_RESERVE: begin
        f = int'(a) / FRAME_BYTES_DEF;
        if (f >= lim) begin
          o.status = ST_RANGE;
        end else if (c == CMD_FREE) begin
          if (frame_used(f)) begin
            frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b0;
            if (frames_used > 0) frames_used--;
          end
        end else if (!frame_used(f)) begin
          frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
          frames_used++;
        end
      end
      default: begin
        mark_all_used();
        frames_used = lim;
      end
    endcase
    o.total = (frames_used > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : TOTAL_W'(frames_used);
  endfunction

  function automatic row_t cfg_row(input logic [FC_W-1:0] v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.fc = v;
    return r;
  endfunction

  function automatic row_t plain_row(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a);
    row_t r;
    r = '0;
    r.cmd = c;
    r.addr = a;
    return r;
  endfunction

  function automatic row_t typed_row(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                                     input logic [ADDR_W-1:0] ea,
                                     input logic [STATUS_W-1:0] es,
                                     input logic [TOTAL_W-1:0] et);
    row_t r;
    r = plain_row(c, a);
    r.typed = 1'b1;
    r.exp.addr = ea;
    r.exp.status = es;
    r.exp.total = et;
    return r;
  endfunction

  // byte address somewhere inside frame f
  function automatic logic [ADDR_W-1:0] addr_in_frame(input int f);
    return ADDR_W'(f * FRAME_BYTES_DEF + $urandom_range(0, FRAME_BYTES_DEF - 1));
  endfunction

  task automatic offer_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                            input bit typed, input outcome_t typed_exp);
    int gap;
    outcome_t o;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = c;
    in_phys_address = a;
    do @(posedge clk); while (in_stall);
    predict_outcome(c, a, o);
    expected_outcomes.push_back(typed ? typed_exp : o);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // written only with the block idle; read back straight after
  task automatic write_frame_count(input logic [FC_W-1:0] v);
    logic [APB_W-1:0] rd;
    drain();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_FRAME_COUNT;
    pwdata = APB_W'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    frame_count_reg = int'(v);
    if (rd[FC_W-1:0] !== v) begin
      $display("%0t: frame_count readback expected %0d actual %0d", $time, v, rd[FC_W-1:0]);
      err_count++;
    end
  endtask

  task automatic offer_random_item(input int lim);
    int r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    a = (lim > 0) ? addr_in_frame($urandom_range(0, lim - 1)) : ADDR_W'($urandom);
    if (r < 35)
      offer_item(CMD_ALLOC, ADDR_W'($urandom), 1'b0, '0);
    else if (r < 65)
      offer_item(CMD_FREE, a, 1'b0, '0);
    else if (r < 80)
      offer_item(CMD_RESERVE, a, 1'b0, '0);
    else if (r < 83)
      offer_item(CMD_REINIT, ADDR_W'($urandom), 1'b0, '0);
    else if (r < 92 && lim < MAX_FRAMES_DEF)
      // beyond the managed range, inside the map
      offer_item($urandom_range(0, 1) ? CMD_FREE : CMD_RESERVE,
                 addr_in_frame($urandom_range(lim, MAX_FRAMES_DEF - 1)), 1'b0, '0);
    else
      offer_item($urandom_range(0, 1) ? CMD_FREE : CMD_RESERVE, ADDR_W'($urandom), 1'b0, '0);
  endtask

  // result side
  initial begin
    int n;
    outcome_t e;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected item addr %h status %0d used %0d", $time,
                 out_result_address, out_status, out_used_total);
        err_count++;
      end else begin
        e = expected_outcomes.pop_front();
        if (out_result_address !== e.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, e.addr,
                   out_result_address);
          err_count++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          err_count++;
        end
        if (out_used_total !== e.total) begin
          $display("%0t: used_total expected %0d actual %0d", $time, e.total, out_used_total);
          err_count++;
        end
      end
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("bitmap_frame_allocator_test NOT OK");
    $finish;
  end

  initial begin
    int phase;
    int lim;
    int sel;
    int fc;
    in_valid = 1'b0;
    in_cmd = '0;
    in_phys_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    mark_all_used();
    frames_used = MAX_FRAMES_DEF;
    frame_count_reg = int'(FC_RESET);

    // everything starts used; frame 0 is never handed out
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'h000000, ST_OOM, 13'd4096));
    plan.push_back(typed_row(CMD_FREE, 24'hFFFFFF, 24'h000000, ST_OK, 13'd4095));
    plan.push_back(typed_row(CMD_FREE, 24'h000000, 24'h000000, ST_OK, 13'd4094));
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'hFFF000, ST_OK, 13'd4095));
    plan.push_back(typed_row(CMD_ALLOC, 24'hFFFFFF, 24'h000000, ST_OOM, 13'd4095));
    plan.push_back(typed_row(CMD_RESERVE, 24'h000FFF, 24'h000000, ST_OK, 13'd4096));
    plan.push_back(typed_row(CMD_RESERVE, 24'h000123, 24'h000000, ST_OK, 13'd4096));
    plan.push_back(typed_row(CMD_FREE, 24'h001000, 24'h000000, ST_OK, 13'd4095));
    plan.push_back(typed_row(CMD_FREE, 24'h001FFF, 24'h000000, ST_OK, 13'd4095));
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'h001000, ST_OK, 13'd4096));
    // count above the map size is clamped
    plan.push_back(cfg_row(13'd8191));
    plan.push_back(typed_row(CMD_FREE, 24'h800000, 24'h000000, ST_OK, 13'd4095));
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'h800000, ST_OK, 13'd4096));
    plan.push_back(plain_row(CMD_FREE, 24'h7FF800));
    plan.push_back(plain_row(CMD_RESERVE, 24'h7FF000));
    plan.push_back(cfg_row(13'd1));
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'h000000, ST_OOM, 13'd4096));
    plan.push_back(typed_row(CMD_FREE, 24'h001000, 24'h000000, ST_RANGE, 13'd4096));
    plan.push_back(typed_row(CMD_REINIT, 24'h000000, 24'h000000, ST_OK, 13'd1));
    // widen again: freeing frames the count never held saturates at zero
    plan.push_back(cfg_row(13'd4096));
    plan.push_back(typed_row(CMD_FREE, 24'h005000, 24'h000000, ST_OK, 13'd0));
    plan.push_back(typed_row(CMD_FREE, 24'h006000, 24'h000000, ST_OK, 13'd0));
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'h005000, ST_OK, 13'd1));
    plan.push_back(cfg_row(13'd0));
    plan.push_back(typed_row(CMD_ALLOC, 24'h000000, 24'h000000, ST_OOM, 13'd1));
    plan.push_back(typed_row(CMD_RESERVE, 24'h000000, 24'h000000, ST_RANGE, 13'd1));
    plan.push_back(typed_row(CMD_REINIT, 24'hFFFFFF, 24'h000000, ST_OK, 13'd0));
    plan.push_back(cfg_row(13'd4096));
    plan.push_back(typed_row(CMD_REINIT, 24'h000000, 24'h000000, ST_OK, 13'd4096));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_frame_count(plan[i].fc);
      else
        offer_item(plan[i].cmd, plan[i].addr, plan[i].typed, plan[i].exp);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0:       fc = 0;
        1:       fc = $urandom_range(MAX_FRAMES_DEF, 8191);
        2:       fc = 1;
        3:       fc = MAX_FRAMES_DEF;
        4:       fc = $urandom_range(1, MAX_FRAMES_DEF);
        default: fc = $urandom_range(2, 300);
      endcase
      write_frame_count(FC_W'(fc));
      lim = frame_limit();
      no_gaps = (phase % 5 == 2);
      if ($urandom_range(0, 3) != 0)
        offer_item(CMD_REINIT, ADDR_W'($urandom), 1'b0, '0);
      // open up some room so that allocations get somewhere
      if (lim > 0) begin
        repeat ((lim < 20) ? lim : 20)
          offer_item(CMD_FREE, addr_in_frame($urandom_range(0, lim - 1)), 1'b0, '0);
      end
      if (phase == 1) begin
        // receiver holds off while items keep coming back to back
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (16) offer_random_item(lim);
        no_gaps = 1'b0;
      end
      repeat (100) offer_random_item(lim);
      phase++;
    end

    drain();
    repeat (150) @(posedge clk);
    if (err_count == 0)
      $display("bitmap_frame_allocator_test OK");
    else
      $display("bitmap_frame_allocator_test NOT OK");
    $finish;
  end

endmodule

/* bitmap_frame_allocator.f */
hdl/bfa_pkg.sv
hdl/bfa_map_ram.sv
hdl/bfa_free_find.sv
hdl/bitmap_frame_allocator.sv
sim/bitmap_frame_allocator_test.sv
